// ===== sv/mec_pkg.sv =====
package mec_pkg;

   localparam int WORD_BITS   = 32;
   localparam int STEP_BITS   = 31;
   localparam int LIMIT_BITS  = 12;
   localparam int COUNT_BITS  = 13;
   localparam int CSR_IDX_BITS = 3;

   // The shared multiplier takes signed operands one bit wider than a word, so that an
   // unsigned step or pixel index fits beside a signed coordinate.
   localparam int MUL_BITS  = WORD_BITS + 1;
   localparam int PROD_BITS = 2 * WORD_BITS;

   localparam int FRAC_BITS_DEF  = 28;
   localparam int COORD_BITS_DEF = 12;

   localparam logic signed [WORD_BITS-1:0] ORIGIN_RE_RST = -32'sd671088640;
   localparam logic signed [WORD_BITS-1:0] ORIGIN_IM_RST = -32'sd536870912;
   localparam logic [STEP_BITS-1:0]        STEP_RE_RST   = 31'd1342177;
   localparam logic [STEP_BITS-1:0]        STEP_IM_RST   = 31'd1342177;
   localparam logic [LIMIT_BITS-1:0]       ITER_LIMIT_RST = 12'd800;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_RE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_IM  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_RE    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_IM    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ITER_LIMIT = 3'd4;

   typedef logic signed [MUL_BITS-1:0]  mul_op_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [WORD_BITS-1:0] word_type;

   function automatic word_type sat_word(input prod_type v);
      word_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic prod_type sext_word(input word_type w);
      return {{(PROD_BITS-WORD_BITS){w[WORD_BITS-1]}}, w};
   endfunction

endpackage

// ===== sv/mec_mult.sv =====
module mec_mult
   import mec_pkg::*;
(
   input  logic       clock,
   input  mul_op_type op_a,
   input  mul_op_type op_b,
   output prod_type   prod
);

   logic signed [2*MUL_BITS-1:0] full_prod;
   prod_type prod_ff;

   assign full_prod = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full_prod[PROD_BITS-1:0];
   end

   assign prod = prod_ff;

endmodule

// ===== sv/mandelbrot_escape_count_core.sv =====
// One item at a time; the next item is taken only after the result is taken.
// Each iteration steps through ST_SQ_RE, ST_SQ_IM, ST_CROSS and ST_UPDATE: one shared 33x33
// multiplier forms re*re, im*im and re*im in turn, and ST_UPDATE does the shift, add and saturate.
// Reset is synchronous and active high; it idles the sequencer and loads the view defaults.
module mandelbrot_escape_count_core
   import mec_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_BITS-1:0]   req_pixel_col,
   input  logic [COORD_BITS-1:0]   req_pixel_row,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COUNT_BITS-1:0]   rsp_iter_count,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata
);

   localparam bit HAS_THR = (2 * FRAC_BITS <= 61);
   localparam logic [PROD_BITS-1:0] ESC_THR =
      HAS_THR ? (64'd4 << (2 * FRAC_BITS)) : '0;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_MAP_IM  = 8'b0000_0010,
      ST_MAP_END = 8'b0000_0100,
      ST_SQ_RE   = 8'b0000_1000,
      ST_SQ_IM   = 8'b0001_0000,
      ST_CROSS   = 8'b0010_0000,
      ST_UPDATE  = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   word_type               origin_re_ff, origin_im_ff;
   logic [STEP_BITS-1:0]   step_re_ff, step_im_ff;
   logic [LIMIT_BITS-1:0]  iter_limit_ff;

   logic [COORD_BITS-1:0]  row_ff;
   word_type               c_re_ff, c_im_ff;
   word_type               re_ff, im_ff;
   prod_type               rr_ff;
   prod_type               diff_ff;
   logic                   esc_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   mul_op_type op_a, op_b;
   prod_type   prod;
   prod_type   sum_c;
   logic [PROD_BITS-1:0] mag;
   prod_type   next_re, next_im;
   logic       stop;

   mec_mult u_mult (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Operand selection for the shared multiplier; each product is used in the next cycle.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            op_a = {{(MUL_BITS-COORD_BITS){1'b0}}, req_pixel_col};
            op_b = {{(MUL_BITS-STEP_BITS){1'b0}}, step_re_ff};
         end
         ST_MAP_IM: begin
            op_a = {{(MUL_BITS-COORD_BITS){1'b0}}, row_ff};
            op_b = {{(MUL_BITS-STEP_BITS){1'b0}}, step_im_ff};
         end
         ST_SQ_RE: begin
            op_a = {re_ff[WORD_BITS-1], re_ff};
            op_b = {re_ff[WORD_BITS-1], re_ff};
         end
         ST_SQ_IM: begin
            op_a = {im_ff[WORD_BITS-1], im_ff};
            op_b = {im_ff[WORD_BITS-1], im_ff};
         end
         default: begin
            op_a = {re_ff[WORD_BITS-1], re_ff};
            op_b = {im_ff[WORD_BITS-1], im_ff};
         end
      endcase
   end

   assign sum_c   = (state_ff == ST_MAP_IM) ? sext_word(origin_re_ff) + prod
                                            : sext_word(origin_im_ff) + prod;
   assign mag     = $unsigned(rr_ff) + $unsigned(prod);
   assign next_re = (diff_ff >>> FRAC_BITS) + sext_word(c_re_ff);
   assign next_im = (prod >>> (FRAC_BITS - 1)) + sext_word(c_im_ff);
   assign stop    = esc_ff || (count_ff > {1'b0, iter_limit_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MAP_IM;
         ST_MAP_IM:  state_in = ST_MAP_END;
         ST_MAP_END: state_in = ST_SQ_RE;
         ST_SQ_RE:   state_in = ST_SQ_IM;
         ST_SQ_IM:   state_in = ST_CROSS;
         ST_CROSS:   state_in = ST_UPDATE;
         ST_UPDATE:  state_in = stop ? ST_DONE : ST_SQ_RE;
         ST_DONE:    if (rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         origin_re_ff  <= ORIGIN_RE_RST;
         origin_im_ff  <= ORIGIN_IM_RST;
         step_re_ff    <= STEP_RE_RST;
         step_im_ff    <= STEP_IM_RST;
         iter_limit_ff <= ITER_LIMIT_RST;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ORIGIN_RE:  origin_re_ff  <= csr_wdata;
               CSR_ORIGIN_IM:  origin_im_ff  <= csr_wdata;
               CSR_STEP_RE:    step_re_ff    <= csr_wdata[STEP_BITS-1:0];
               CSR_STEP_IM:    step_im_ff    <= csr_wdata[STEP_BITS-1:0];
               CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            row_ff <= req_pixel_row;
         end
         ST_MAP_IM: begin
            c_re_ff <= sat_word(sum_c);
         end
         ST_MAP_END: begin
            c_im_ff  <= sat_word(sum_c);
            re_ff    <= '0;
            im_ff    <= '0;
            count_ff <= '0;
         end
         ST_SQ_IM: begin
            rr_ff <= prod;
         end
         ST_CROSS: begin
            // The product here is im*im; the escape test uses the exact sum of squares.
            esc_ff  <= HAS_THR && (mag >= ESC_THR);
            diff_ff <= rr_ff - prod;
         end
         ST_UPDATE: begin
            if (!stop) begin
               re_ff    <= sat_word(next_re);
               im_ff    <= sat_word(next_im);
               count_ff <= count_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_iter_count = count_ff;

   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iter_count != '0))
      else $error("result item with zero iteration count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (count_ff <= ({1'b0, iter_limit_ff} + 1'b1)))
      else $error("iteration count ran past limit plus one");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAP_IM))
      else $error("accepted item did not start the mapping");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("block not ready after result item was taken");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready for a new item while a result is pending");

endmodule

// ===== dv/mandelbrot_escape_count_checker.sv =====
module mandelbrot_escape_count_checker
   import mec_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [COORD_BITS_DEF-1:0] req_pixel_col,
   input  logic [COORD_BITS_DEF-1:0] req_pixel_row,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [COUNT_BITS-1:0]     rsp_iter_count,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata,
   output int                        mismatch_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint signed WORD_MAX = 64'sd2147483647;
   localparam longint signed WORD_MIN = -64'sd2147483648;
   // With a wide fraction the escape radius no longer fits in 64 bits and only the limit stops.
   localparam bit HAS_ESCAPE_TEST = (2 * FRAC_BITS_DEF) <= 61;
   localparam longint unsigned ESCAPE_RADIUS_SQ =
      HAS_ESCAPE_TEST ? (64'd4 << (2 * FRAC_BITS_DEF)) : 64'd0;

   typedef struct packed {
      logic [COORD_BITS_DEF-1:0] col;
      logic [COORD_BITS_DEF-1:0] row;
      logic [COUNT_BITS-1:0]     count;
   } pixel_count_type;

   word_type               view_re;
   word_type               view_im;
   logic [STEP_BITS-1:0]   pitch_re;
   logic [STEP_BITS-1:0]   pitch_im;
   logic [LIMIT_BITS-1:0]  count_cap;
   pixel_count_type        expected_counts[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic longint signed clamp_word(input longint signed v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic logic [COUNT_BITS-1:0] escape_count(input logic [COORD_BITS_DEF-1:0] col,
                                                          input logic [COORD_BITS_DEF-1:0] row);
      longint signed   c_re;
      longint signed   c_im;
      longint signed   re;
      longint signed   im;
      longint signed   rr;
      longint signed   ii;
      longint signed   ri;
      longint unsigned mag;
      int unsigned     count;
      c_re  = clamp_word(longint'(view_re) + longint'(col) * longint'(pitch_re));
      c_im  = clamp_word(longint'(view_im) + longint'(row) * longint'(pitch_im));
      re    = 0;
      im    = 0;
      count = 0;
      forever begin
         rr  = re * re;
         ii  = im * im;
         mag = rr + ii;
         if (HAS_ESCAPE_TEST && mag >= ESCAPE_RADIUS_SQ) break;
         if (count > count_cap) break;
         ri = re * im;
         re = clamp_word(((rr - ii) >>> FRAC_BITS_DEF) + c_re);
         im = clamp_word((ri >>> (FRAC_BITS_DEF - 1)) + c_im);
         count++;
      end
      return count[COUNT_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pixel_count_type oldest;
      if (reset) begin
         view_re   = ORIGIN_RE_RST;
         view_im   = ORIGIN_IM_RST;
         pitch_re  = STEP_RE_RST;
         pitch_im  = STEP_IM_RST;
         count_cap = ITER_LIMIT_RST;
         expected_counts.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_RE:  view_re   = csr_wdata;
               CSR_ORIGIN_IM:  view_im   = csr_wdata;
               CSR_STEP_RE:    pitch_re  = csr_wdata[STEP_BITS-1:0];
               CSR_STEP_IM:    pitch_im  = csr_wdata[STEP_BITS-1:0];
               CSR_ITER_LIMIT: count_cap = csr_wdata[LIMIT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            oldest.col   = req_pixel_col;
            oldest.row   = req_pixel_row;
            oldest.count = escape_count(req_pixel_col, req_pixel_row);
            expected_counts.push_back(oldest);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("count %0d arrived with no pixel outstanding",
                                         rsp_iter_count));
            end else begin
               oldest = expected_counts.pop_front();
               if (rsp_iter_count !== oldest.count) begin
                  report_mismatch($sformatf("pixel (%0d,%0d): iter_count %0d, expected %0d",
                                            oldest.col, oldest.row, rsp_iter_count,
                                            oldest.count));
               end
            end
         end
         pending_count <= expected_counts.size();
      end
   end

endmodule

// ===== dv/mandelbrot_escape_count_core_tb.sv =====
module mandelbrot_escape_count_core_tb
   import mec_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RAND_PHASES      = 14;
   localparam int  ITEMS_PER_PHASE  = 53;
   localparam int  CYCLE_LIMIT      = 3000000;
   localparam int  SETTLE_CYCLES    = 64;
   localparam logic [COORD_BITS_DEF-1:0] COORD_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [COORD_BITS_DEF-1:0] req_pixel_col;
   logic [COORD_BITS_DEF-1:0] req_pixel_row;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [COUNT_BITS-1:0]     rsp_iter_count;
   logic                      csr_wr_en;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [WORD_BITS-1:0]      csr_wdata;

   int   mismatch_count;
   int   pending_count;
   int   cycle_count;
   int   ready_hold;
   int   pixels_sent;
   int   view_settings;
   logic quiet;

   mandelbrot_escape_count_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_iter_count (rsp_iter_count),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   mandelbrot_escape_count_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_iter_count (rsp_iter_count),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d pixels outstanding",
                  cycle_count, pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The result side stalls in bursts; once the run goes quiet it always takes results.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 13);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 19);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Unused upper bits of the step and limit writes carry random junk.
   task automatic apply_view(input word_type o_re, input word_type o_im,
                             input logic [STEP_BITS-1:0] s_re, input logic [STEP_BITS-1:0] s_im,
                             input logic [LIMIT_BITS-1:0] lim);
      logic [WORD_BITS-1:0] junk;
      junk = $urandom;
      write_csr(CSR_ORIGIN_RE, o_re);
      write_csr(CSR_ORIGIN_IM, o_im);
      write_csr(CSR_STEP_RE, {junk[WORD_BITS-1], s_re});
      write_csr(CSR_STEP_IM, {junk[0], s_im});
      write_csr(CSR_ITER_LIMIT, {junk[WORD_BITS-1:LIMIT_BITS], lim});
      csr_wr_en <= 1'b0;
      @(posedge clock);
      view_settings++;
   endtask

   // Returns at the edge where the item is accepted; valid stays high for a following item.
   task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] col,
                             input logic [COORD_BITS_DEF-1:0] row);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // The extra edge lets the checker count an item accepted at the current edge.
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      word_type              o_re;
      word_type              o_im;
      logic [STEP_BITS-1:0]  s_re;
      logic [STEP_BITS-1:0]  s_im;
      logic [LIMIT_BITS-1:0] lim;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      quiet         = 1'b0;
      cycle_count   = 0;
      ready_hold    = 0;
      pixels_sent   = 0;
      view_settings = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default view: corners, the origin (never escapes) and points in the period-2 bulb.
      send_pixel('0, '0);
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel(COORD_BITS_DEF'(500), COORD_BITS_DEF'(400));
      send_pixel(COORD_BITS_DEF'(250), COORD_BITS_DEF'(400));
      send_pixel('0, COORD_MAX);
      send_pixel(COORD_MAX, '0);
      send_pixel(COORD_BITS_DEF'(350), COORD_BITS_DEF'(400));
      wait_drain();

      // A zero limit still runs one iteration.
      apply_view(ORIGIN_RE_RST, ORIGIN_IM_RST, STEP_RE_RST, STEP_IM_RST, '0);
      send_pixel(COORD_BITS_DEF'(500), COORD_BITS_DEF'(400));
      send_pixel('0, '0);
      wait_drain();

      // The largest limit on a point inside the set gives the largest count.
      apply_view(ORIGIN_RE_RST, ORIGIN_IM_RST, STEP_RE_RST, STEP_IM_RST, '1);
      send_pixel(COORD_BITS_DEF'(500), COORD_BITS_DEF'(400));
      wait_drain();

      // Extreme origins and steps; in the first view large pixel indexes saturate the mapped point.
      apply_view(32'sh7FFFFFFF, 32'sh80000000, '1, '1, 12'd1);
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel('0, '0);
      send_pixel(COORD_MAX, '0);
      wait_drain();
      apply_view(32'sh80000000, 32'sh80000000, '0, '0, '1);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_drain();

      // Writes to unused register indexes must leave the view alone.
      for (int i = CSR_ITER_LIMIT + 1; i < (1 << CSR_IDX_BITS); i++) begin
         write_csr(i[CSR_IDX_BITS-1:0], $urandom);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      send_pixel('0, '0);
      wait_drain();

      // Zero origin and step: every pixel stays at zero and runs to the limit.
      apply_view('0, '0, '0, '0, 12'd1);
      send_pixel(COORD_BITS_DEF'(123), COORD_BITS_DEF'(456));
      wait_drain();

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p == RAND_PHASES - 1) begin
            quiet <= 1'b1;
         end
         if (p % 4 == 3) begin
            o_re = $urandom;
            o_im = $urandom;
            s_re = STEP_BITS'($urandom);
            s_im = STEP_BITS'($urandom);
         end else begin
            // A window around the set, so that counts spread over the whole range.
            o_re = $urandom_range(134217728, 671088640);
            o_re = -o_re;
            o_im = $urandom_range(134217728, 536870912);
            o_im = -o_im;
            s_re = STEP_BITS'($urandom_range(0, 229376));
            s_im = STEP_BITS'($urandom_range(0, 262144));
         end
         if (p == 2) begin
            lim = 12'd1;
         end else if ($urandom_range(0, 9) == 0) begin
            lim = LIMIT_BITS'($urandom_range(100, 200));
         end else begin
            lim = LIMIT_BITS'($urandom_range(1, 40));
         end
         apply_view(o_re, o_im, s_re, s_im, lim);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_pixel(COORD_BITS_DEF'($urandom_range(0, COORD_MAX)),
                       COORD_BITS_DEF'($urandom_range(0, COORD_MAX)));
            if (p == 1 && i == ITEMS_PER_PHASE / 2) begin
               wait_drain();
            end
         end
         wait_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Summary: %0d pixels over %0d view settings, zero and full limits included,",
               pixels_sent, view_settings);
      $display("saturated points, unused register writes and random stalls on both channels.");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
